// File: hw/rtl/indexed_sequence_store_unit_macros.svh
// ----------------------------------------------------------------------------
// indexed sequence store assertion macros
// shared concurrent assertion forms for the store's rtl
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH

// same-cycle implication
`define ISU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg
// types and codes shared by the indexed sequence store and its cells
// ----------------------------------------------------------------------------
package isu_pkg;

  localparam int MODE_W     = 4;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 16;
  localparam int STAT_W     = 2;
  localparam int LEN_W      = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 104;
  // wide enough for any position up to the largest supported capacity
  localparam int POS_W      = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 4'd0,
    MODE_APPEND     = 4'd1,
    MODE_INSERT_AT  = 4'd2,
    MODE_POP_BACK   = 4'd3,
    MODE_DROP_HEAD  = 4'd4,
    MODE_REMOVE_AT  = 4'd5,
    MODE_QUERY      = 4'd6,
    MODE_CLEAR      = 4'd7,
    MODE_DUMP       = 4'd8,
    MODE_DUMP_REV   = 4'd9
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] wr_pos;
    logic [POS_W-1:0] rd_pos;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

endpackage

// File: hw/rtl/isu_cell.sv
// ----------------------------------------------------------------------------
// isu_cell
// one storage cell of the row: shifts with its neighbors on insert and
// remove, and drives the read tap chain when selected
// ----------------------------------------------------------------------------
module isu_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  isu_pkg::cell_ctrl_t       ctrl_i,
  input  logic [DATA_WIDTH-1:0]     word_i,
  input  logic [DATA_WIDTH-1:0]     left_i,
  input  logic [DATA_WIDTH-1:0]     right_i,
  output logic [DATA_WIDTH-1:0]     data_o,
  // {prev, next, elem}, elem in the lowest bits
  input  logic [3*DATA_WIDTH-1:0]   tap_i,
  output logic [3*DATA_WIDTH-1:0]   tap_o
);
  import isu_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl_i.op)
      CELL_INS: begin
        if (MY_POS > ctrl_i.wr_pos) begin
          data_nxt = left_i;
        end else if (MY_POS == ctrl_i.wr_pos) begin
          data_nxt = word_i;
        end
      end
      CELL_DEL: begin
        if (MY_POS >= ctrl_i.wr_pos) begin
          data_nxt = right_i;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // selected cell puts itself and both neighbors on the tap chain
  assign tap_o  = (MY_POS == ctrl_i.rd_pos) ? (tap_i | {left_i, right_i, data_r}) : tap_i;

endmodule

// File: hw/rtl/indexed_sequence_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit
// bounded ordered sequence of signed words kept in a row of shifting cells
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Inserts, removals, pops, queries,
// clears and unknown modes pass the accept cycle, then an execute state
// that waits for a free result register, shifts the cell row, reads the
// tap chain or only changes the fill count, and registers the result. A
// dump then yields one result per cycle, unless the result side stalls,
// read from the tap chain at a running position. The result register
// frees the input side, so a new transaction is accepted while the
// previous result still waits on out_tready. No clearing pass follows
// reset: it zeroes state, fill count, dump step and output valid only.
`include "indexed_sequence_store_unit_macros.svh"

module indexed_sequence_store_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] value, [47:32] index
  input  logic [isu_pkg::IN_DATA_W-1:0]     in_tdata,
  // [3:0] mode
  input  logic [isu_pkg::MODE_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] element_value, [63:32] next_value, [64] has_next,
  // [96:65] prev_value, [97] has_prev, [102:98] length, [103] zero
  output logic [isu_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [isu_pkg::STAT_W-1:0]        out_tuser,
  output logic                              out_tlast
);
  import isu_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = 3 * DATA_WIDTH;

  function automatic logic [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[VAL_W-1:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic [MODE_W-1:0]      mode_r;
  logic [DATA_WIDTH-1:0]  word_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          step_r, step_nxt;

  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  status_t                out_user_r;
  logic                   out_last_r;

  logic                   out_free;
  logic                   out_load;
  status_t                res_status;
  logic                   res_last;
  logic [VAL_W-1:0]       res_elem, res_next, res_prev;
  logic                   res_hn, res_hp;

  logic signed [63:0]     word_ext;
  logic                   full, empty, idx_neg, idx_ge, idx_le0;
  logic [CW-1:0]          idx_pos, ins_pos, qry_pos, dump_pos;
  logic                   qry_hn, qry_hp;

  cell_ctrl_t             ctrl;
  logic [CW-1:0]          wr_pos, rd_pos;
  cell_op_t               cell_op;

  logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
  logic [TW-1:0]          tap_chain [CAPACITY+1];
  logic [TW-1:0]          tap;

  // cell row
  assign tap_chain[0] = '0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    isu_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl_i  (ctrl),
      .word_i  (word_r),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .tap_i   (tap_chain[i]),
      .tap_o   (tap_chain[i+1])
    );
  end
  assign tap = tap_chain[CAPACITY];

  assign ctrl = '{op: cell_op, wr_pos: POS_W'(wr_pos), rd_pos: POS_W'(rd_pos)};

  // index decode
  assign word_ext = 64'(signed'(in_tdata[VAL_W-1:0]));
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign idx_neg  = idx_r[IDX_W-1];
  assign idx_ge   = !idx_neg && (idx_r >= IDX_W'(count_r));
  assign idx_le0  = idx_neg || (idx_r == '0);
  assign idx_pos  = idx_r[CW-1:0];
  assign qry_pos  = idx_neg ? '0 : idx_pos;
  assign qry_hn   = (CW'(qry_pos + CW'(1)) < count_r);
  assign qry_hp   = (qry_pos != '0);
  assign dump_pos = (mode_r == MODE_DUMP_REV) ? CW'(count_r - CW'(1) - step_r) : step_r;

  always_comb begin
    ins_pos = '0;
    if (mode_r == MODE_APPEND) begin
      ins_pos = count_r;
    end else if (mode_r == MODE_INSERT_AT) begin
      if (idx_le0) begin
        ins_pos = '0;
      end else if (idx_ge) begin
        ins_pos = count_r;
      end else begin
        ins_pos = idx_pos;
      end
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    cell_op    = CELL_HOLD;
    wr_pos     = '0;
    rd_pos     = '0;
    out_load   = 1'b0;
    res_status = ST_OK;
    res_last   = 1'b1;
    res_elem   = '0;
    res_next   = '0;
    res_prev   = '0;
    res_hn     = 1'b0;
    res_hp     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_pos = qry_pos;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          unique case (mode_r) inside
            MODE_PUSH_FRONT, MODE_APPEND, MODE_INSERT_AT: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                cell_op   = CELL_INS;
                wr_pos    = ins_pos;
                count_nxt = CW'(count_r + CW'(1));
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                count_nxt = CW'(count_r - CW'(1));
              end
            end
            MODE_DROP_HEAD: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                cell_op   = CELL_DEL;
                count_nxt = CW'(count_r - CW'(1));
              end
            end
            MODE_REMOVE_AT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (idx_neg || idx_ge) begin
                res_status = ST_RANGE;
              end else begin
                cell_op   = CELL_DEL;
                wr_pos    = idx_pos;
                count_nxt = CW'(count_r - CW'(1));
              end
            end
            MODE_QUERY: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (idx_ge) begin
                res_status = ST_RANGE;
              end else begin
                res_elem = to_out(tap[DATA_WIDTH-1:0]);
                res_hn   = qry_hn;
                res_hp   = qry_hp;
                res_next = qry_hn ? to_out(tap[2*DATA_WIDTH-1:DATA_WIDTH]) : '0;
                res_prev = qry_hp ? to_out(tap[3*DATA_WIDTH-1:2*DATA_WIDTH]) : '0;
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            MODE_DUMP, MODE_DUMP_REV: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                out_load  = 1'b0;
                state_nxt = S_DUMP;
                step_nxt  = '0;
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        rd_pos = dump_pos;
        if (out_free) begin
          out_load = 1'b1;
          res_elem = to_out(tap[DATA_WIDTH-1:0]);
          res_last = (CW'(step_r + CW'(1)) == count_r);
          if (res_last) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = CW'(step_r + CW'(1));
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_data_nxt = {1'b0, LEN_W'(count_nxt), res_hp, res_prev, res_hn, res_next, res_elem};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_tuser;
      word_r <= word_ext[DATA_WIDTH-1:0];
      idx_r  <= in_tdata[IN_DATA_W-1:VAL_W];
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= res_status;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `ISU_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "count too big")
  `ISU_ASSERT_NXT(a_accept_exec, clk, rst_n, in_tvalid && in_tready, state_r == S_EXEC, "no exec")
  `ISU_ASSERT_IMP(a_dump_nonempty, clk, rst_n, state_r == S_DUMP, count_r != '0, "empty dump")
  `ISU_ASSERT_NXT(a_full_hold, clk, rst_n, out_load && res_status == ST_FULL, $stable(count_r), "drop")

endmodule
